FILE: rtl/cpd_pkg.sv
`timescale 1ns / 1ps
// Package for the contour Pareto dominance block.
// Holds the sequencer state type, field widths and verdict codes; no dependencies.
package cpd_pkg;

    localparam int AVAIL_W = 16;
    localparam int LEN_W   = 32;
    localparam int LIM_W   = AVAIL_W + 1;

    localparam logic [1:0] VERDICT_INC_KEEP = 2'd0;
    localparam logic [1:0] VERDICT_NONE     = 2'd1;
    localparam logic [1:0] VERDICT_CAND     = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BACK,
        ST_BLAST,
        ST_FWD,
        ST_FLAST,
        ST_VERD
    } t_state;

endpackage

FILE: rtl/cpd_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cpd_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/contour_pareto_dominance.sv
`timescale 1ns / 1ps
// Contour Pareto dominance: incumbent versus candidate routing solution.
// A non-last column request is accepted without raising busy. A last column request
// keeps busy high through a backward suffix-minimum pass and a forward
// clamp/compare pass, each one RAM read per column. The verdict strobe rises
// after both passes; the receiver cannot stall it.
// Synchronous active-low reset clears the column count, sequencer and use_contours (to 1).
module contour_pareto_dominance #(
    parameter int MAX_COLUMNS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_wdata,
    input  logic [cpd_pkg::AVAIL_W-1:0] i_inc_capacity,
    input  logic [cpd_pkg::AVAIL_W-1:0] i_inc_point,
    input  logic [cpd_pkg::AVAIL_W-1:0] i_cand_capacity,
    input  logic [cpd_pkg::AVAIL_W-1:0] i_cand_point,
    input  logic [cpd_pkg::LEN_W-1:0]   i_inc_critical,
    input  logic [cpd_pkg::LEN_W-1:0]   i_inc_total,
    input  logic [cpd_pkg::LEN_W-1:0]   i_cand_critical,
    input  logic [cpd_pkg::LEN_W-1:0]   i_cand_total,
    input  logic                       i_last_column,
    output logic                       o_verdict_valid,
    output logic [1:0]                 o_verdict
);

    import cpd_pkg::*;

    localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam int RW = 2 * AVAIL_W;
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_COLUMNS);

    t_state r_state, n_state;

    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_addr, n_addr;
    logic [AW-1:0]      r_end_addr, n_end_addr;
    logic [AW-1:0]      r_paddr, n_paddr;
    logic               r_pv, n_pv;
    logic               r_use_contours;
    logic [AVAIL_W-1:0] r_smin_inc, n_smin_inc;
    logic [AVAIL_W-1:0] r_smin_cand, n_smin_cand;
    logic [LIM_W-1:0]   r_lim_inc, n_lim_inc;
    logic [LIM_W-1:0]   r_lim_cand, n_lim_cand;
    logic               r_cand_le, n_cand_le;
    logic               r_inc_le, n_inc_le;
    logic [LEN_W-1:0]   r_ic, r_it, r_cc, r_ct;
    logic               r_out_valid, n_out_valid;
    logic [1:0]         r_verdict, n_verdict;

    logic               accept;
    logic               store_col;
    logic [CW-1:0]      count_after;
    logic [AVAIL_W-1:0] avail_inc, avail_cand;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [RW-1:0]      ram_wdata;
    logic [RW-1:0]      ram_rdata;
    logic [AVAIL_W-1:0] rd_inc, rd_cand;
    logic [AVAIL_W-1:0] min_inc, min_cand;
    logic [AVAIL_W-1:0] prof_inc, prof_cand;
    logic               inc_ok, cand_ok;

    cpd_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_COLUMNS),
        .ADDR_W(AW)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_addr),
        .o_rdata(ram_rdata)
    );

    assign accept      = start && (r_state == ST_IDLE);
    assign store_col   = r_count < COUNT_MAX;
    assign count_after = store_col ? r_count + CW'(1) : r_count;
    assign avail_inc   = (i_inc_capacity > i_inc_point) ? i_inc_capacity - i_inc_point : '0;
    assign avail_cand  = (i_cand_capacity > i_cand_point) ? i_cand_capacity - i_cand_point : '0;

    assign rd_inc   = ram_rdata[RW-1:AVAIL_W];
    assign rd_cand  = ram_rdata[AVAIL_W-1:0];
    assign min_inc  = (rd_inc < r_smin_inc) ? rd_inc : r_smin_inc;
    assign min_cand = (rd_cand < r_smin_cand) ? rd_cand : r_smin_cand;
    assign prof_inc  = ({1'b0, rd_inc} > r_lim_inc) ? r_lim_inc[AVAIL_W-1:0] : rd_inc;
    assign prof_cand = ({1'b0, rd_cand} > r_lim_cand) ? r_lim_cand[AVAIL_W-1:0] : rd_cand;

    assign inc_ok  = !r_use_contours || r_cand_le;
    assign cand_ok = !r_use_contours || r_inc_le;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_count[AW-1:0];
        ram_wdata = {avail_inc, avail_cand};
        if (accept && store_col) begin
            ram_we = 1'b1;
        end else if ((r_state == ST_BACK || r_state == ST_BLAST) && r_pv) begin
            ram_we    = 1'b1;
            ram_waddr = r_paddr;
            ram_wdata = {min_inc, min_cand};
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_addr      = r_addr;
        n_end_addr  = r_end_addr;
        n_paddr     = r_addr;
        n_pv        = 1'b0;
        n_smin_inc  = r_smin_inc;
        n_smin_cand = r_smin_cand;
        n_lim_inc   = r_lim_inc;
        n_lim_cand  = r_lim_cand;
        n_cand_le   = r_cand_le;
        n_inc_le    = r_inc_le;
        n_out_valid = 1'b0;
        n_verdict   = r_verdict;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_last_column) begin
                        n_count     = '0;
                        n_addr      = AW'(count_after - CW'(1));
                        n_end_addr  = AW'(count_after - CW'(1));
                        n_smin_inc  = '1;
                        n_smin_cand = '1;
                        n_state     = ST_BACK;
                    end else begin
                        n_count = count_after;
                    end
                end
            end
            ST_BACK: begin
                n_pv = 1'b1;
                if (r_pv) begin
                    n_smin_inc  = min_inc;
                    n_smin_cand = min_cand;
                end
                if (r_addr == '0) begin
                    n_state = ST_BLAST;
                end else begin
                    n_addr = r_addr - AW'(1);
                end
            end
            ST_BLAST: begin
                n_addr     = '0;
                n_lim_inc  = '0;
                n_lim_cand = '0;
                n_cand_le  = 1'b1;
                n_inc_le   = 1'b1;
                n_state    = ST_FWD;
            end
            ST_FWD, ST_FLAST: begin
                if (r_pv) begin
                    n_lim_inc  = {1'b0, prof_inc} + LIM_W'(1);
                    n_lim_cand = {1'b0, prof_cand} + LIM_W'(1);
                    n_cand_le  = r_cand_le && (prof_cand <= prof_inc);
                    n_inc_le   = r_inc_le && (prof_inc <= prof_cand);
                end
                if (r_state == ST_FLAST) begin
                    n_state = ST_VERD;
                end else begin
                    n_pv = 1'b1;
                    if (r_addr == r_end_addr) begin
                        n_state = ST_FLAST;
                    end else begin
                        n_addr = r_addr + AW'(1);
                    end
                end
            end
            ST_VERD: begin
                n_out_valid = 1'b1;
                if (r_cc >= r_ic && r_ct >= r_it && inc_ok) begin
                    n_verdict = VERDICT_INC_KEEP;
                end else if (r_cc <= r_ic && r_ct <= r_it && cand_ok) begin
                    n_verdict = VERDICT_CAND;
                end else begin
                    n_verdict = VERDICT_NONE;
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_count        <= '0;
            r_pv           <= 1'b0;
            r_out_valid    <= 1'b0;
            r_use_contours <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pv        <= n_pv;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_use_contours <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_end_addr  <= n_end_addr;
        r_paddr     <= n_paddr;
        r_smin_inc  <= n_smin_inc;
        r_smin_cand <= n_smin_cand;
        r_lim_inc   <= n_lim_inc;
        r_lim_cand  <= n_lim_cand;
        r_cand_le   <= n_cand_le;
        r_inc_le    <= n_inc_le;
        r_verdict   <= n_verdict;
        if (accept && i_last_column) begin
            r_ic <= i_inc_critical;
            r_it <= i_inc_total;
            r_cc <= i_cand_critical;
            r_ct <= i_cand_total;
        end
    end

    assign busy            = (r_state != ST_IDLE);
    assign o_verdict_valid = r_out_valid;
    assign o_verdict       = r_verdict;

endmodule
